@@ rtl/hprs_pkg.sv @@
// Shared types and constants of the heater and pump recipe sequencer.
`default_nettype none

package hprs_pkg;

  localparam int NUM_WORKFLOWS_DEF = 8;
  localparam int MAX_STEPS_DEF     = 16;
  localparam int TEMP_MARGIN       = 5;

  typedef enum logic [2:0] {
    ACT_TICK        = 3'd0,
    ACT_START       = 3'd1,
    ACT_IDLE        = 3'd2,
    ACT_WRITE_STEP  = 3'd3,
    ACT_WRITE_COUNT = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    OP_SET_TEMP  = 2'd0,
    OP_WAIT_TEMP = 2'd1,
    OP_DELAY     = 2'd2,
    OP_PUMP_RUN  = 2'd3
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] value;
  } step_entry_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [2:0]  wf;
    logic [3:0]  st;
    logic [1:0]  op;
    logic [15:0] val;
    logic [4:0]  cnt;
    logic [31:0] now;
    logic [15:0] temp;
  } item_t;

  typedef struct packed {
    logic        running;
    logic [4:0]  step_position;
    logic [4:0]  step_total;
    op_t         current_op;
    logic [15:0] start_value;
    logic [15:0] current_value;
    logic [15:0] target_temp;
    logic        heater_on;
    logic        pump_on;
    logic        finished;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/hprs_step_mem.sv @@
// Step table memory: one write port, one registered read port with write bypass.
`default_nettype none

module hprs_step_mem #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  hprs_pkg::step_entry_t     wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output hprs_pkg::step_entry_t     rd_data
);
  import hprs_pkg::*;

  step_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // A write at the same edge as the read returns the new entry.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/hprs_core.sv @@
// Recipe state, step sequencing and step table addressing.
`default_nettype none

module hprs_core #(
  parameter int NUM_WORKFLOWS = 8,
  parameter int MAX_STEPS     = 16,
  parameter int MEM_AW        = 7
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write_en,
  input  logic [3:0]            cfg_write_data,
  input  logic                  proc,
  input  hprs_pkg::item_t       item,
  input  logic                  in_accept,
  input  logic [2:0]            in_action,
  input  logic [2:0]            in_wf,
  input  hprs_pkg::step_entry_t rd_data,
  output logic                  wr_en,
  output logic [MEM_AW-1:0]     wr_addr,
  output hprs_pkg::step_entry_t wr_data,
  output logic                  rd_en,
  output logic [MEM_AW-1:0]     rd_addr,
  output hprs_pkg::result_t     result
);
  import hprs_pkg::*;

  localparam int WF_AW = (NUM_WORKFLOWS > 1) ? $clog2(NUM_WORKFLOWS) : 1;
  localparam logic signed [17:0] MARGIN = 18'(TEMP_MARGIN);

  function automatic logic [MEM_AW-1:0] entry_addr(input logic [2:0] wf,
                                                    input logic [5:0] st);
    int a;
    a = int'(wf) * MAX_STEPS + int'(st);
    return MEM_AW'(a);
  endfunction

  logic [3:0]  wf_limit;
  logic        run,        run_next;
  logic [2:0]  act_wf,     act_wf_next;
  logic [4:0]  act_step,   act_step_next;
  logic [31:0] start_time, start_time_next;
  logic [15:0] begin_val,  begin_val_next;
  logic [15:0] latest,     latest_next;
  logic [15:0] setpoint,   setpoint_next;
  logic        heater,     heater_next;
  logic        pump,       pump_next;
  logic [4:0]  act_total,  act_total_next;
  op_t         cur_op,     cur_op_next;
  logic [15:0] cur_val,    cur_val_next;
  logic [4:0]  counts      [NUM_WORKFLOWS];
  logic [4:0]  counts_next [NUM_WORKFLOWS];
  logic        finished;
  logic        enter;

  logic [WF_AW-1:0]   wf_idx;
  logic               wf_ok;
  logic               st_ok;
  logic [4:0]         start_count;
  logic [4:0]         cnt_sat;
  logic [4:0]         step_inc;
  logic [31:0]        elapsed;
  logic signed [17:0] temp_s;
  logic signed [17:0] limit_s;
  logic               step_done;

  assign wf_idx      = WF_AW'(item.wf);
  assign wf_ok       = int'(item.wf) < NUM_WORKFLOWS;
  assign st_ok       = int'(item.st) < MAX_STEPS;
  assign start_count = counts[wf_idx];
  assign cnt_sat     = (int'(item.cnt) > MAX_STEPS) ? 5'(MAX_STEPS) : item.cnt;
  assign step_inc    = act_step + 5'd1;
  assign elapsed     = item.now - start_time;
  assign temp_s      = $signed({2'b00, item.temp});
  assign limit_s     = $signed({2'b00, cur_val}) - MARGIN;

  always_comb begin
    unique case (cur_op)
      OP_SET_TEMP:  step_done = 1'b1;
      OP_WAIT_TEMP: step_done = temp_s >= limit_s;
      OP_DELAY:     step_done = elapsed >= {16'd0, cur_val};
      OP_PUMP_RUN:  step_done = elapsed >= {16'd0, cur_val};
    endcase
  end

  always_comb begin
    run_next        = run;
    act_wf_next     = act_wf;
    act_step_next   = act_step;
    start_time_next = start_time;
    begin_val_next  = begin_val;
    latest_next     = latest;
    setpoint_next   = setpoint;
    heater_next     = heater;
    pump_next       = pump;
    act_total_next  = act_total;
    cur_op_next     = cur_op;
    cur_val_next    = cur_val;
    counts_next     = counts;
    finished        = 1'b0;
    enter           = 1'b0;
    wr_en           = 1'b0;
    wr_addr         = entry_addr(item.wf, {2'b00, item.st});
    wr_data         = '{op: op_t'(item.op), value: item.val};

    if (proc) begin
      unique case (item.action)
        ACT_TICK: begin
          if (run) begin
            unique case (cur_op)
              OP_SET_TEMP: ;
              OP_WAIT_TEMP: begin
                if (begin_val == 16'd0) begin
                  begin_val_next = item.temp;
                end
                latest_next = item.temp;
              end
              OP_DELAY,
              OP_PUMP_RUN: latest_next = elapsed[15:0];
            endcase
            if (step_done) begin
              if (cur_op == OP_PUMP_RUN) begin
                pump_next = 1'b0;
              end
              act_step_next = step_inc;
              if (step_inc >= act_total) begin
                run_next    = 1'b0;
                heater_next = 1'b0;
                finished    = 1'b1;
              end else begin
                enter = 1'b1;
              end
            end
          end
        end
        ACT_START: begin
          if (!run && ({1'b0, item.wf} < wf_limit) && wf_ok && (start_count != 5'd0)) begin
            run_next       = 1'b1;
            act_wf_next    = item.wf;
            act_step_next  = 5'd0;
            heater_next    = 1'b1;
            act_total_next = start_count;
            enter          = 1'b1;
          end
        end
        ACT_IDLE: run_next = 1'b0;
        ACT_WRITE_STEP: begin
          if (wf_ok && st_ok) begin
            wr_en = 1'b1;
            // Keep the cached copy of the active step in line with the table.
            if ((item.wf == act_wf) && ({1'b0, item.st} == act_step)) begin
              cur_op_next  = op_t'(item.op);
              cur_val_next = item.val;
            end
          end
        end
        ACT_WRITE_COUNT: begin
          if (wf_ok) begin
            counts_next[wf_idx] = cnt_sat;
            if (item.wf == act_wf) begin
              act_total_next = cnt_sat;
            end
          end
        end
        default: ;
      endcase
    end

    // The read port already holds the entry of the step being entered.
    if (enter) begin
      cur_op_next  = rd_data.op;
      cur_val_next = rd_data.value;
      if ((rd_data.op == OP_SET_TEMP) || (rd_data.op == OP_WAIT_TEMP)) begin
        begin_val_next = item.temp;
        setpoint_next  = rd_data.value;
      end else begin
        if (rd_data.op == OP_PUMP_RUN) begin
          pump_next = 1'b1;
        end
        start_time_next = item.now;
        begin_val_next  = 16'd0;
      end
      latest_next = begin_val_next;
    end
  end

  // The request arriving now is processed next, so its lookahead entry is read
  // against the state that this cycle leaves behind.
  assign rd_en   = in_accept;
  assign rd_addr = (in_action == ACT_START) ? entry_addr(in_wf, 6'd0)
                                             : entry_addr(act_wf_next,
                                                          {1'b0, act_step_next} + 6'd1);

  always_comb begin
    result.running       = run_next;
    result.step_position = act_step_next;
    result.step_total    = act_total_next;
    result.current_op    = run_next ? cur_op_next : OP_SET_TEMP;
    result.start_value   = begin_val_next;
    result.current_value = latest_next;
    result.target_temp   = setpoint_next;
    result.heater_on     = heater_next;
    result.pump_on       = pump_next;
    result.finished      = finished;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wf_limit   <= 4'd0;
      run        <= 1'b0;
      act_wf     <= 3'd0;
      act_step   <= 5'd0;
      start_time <= 32'd0;
      begin_val  <= 16'd0;
      latest     <= 16'd0;
      setpoint   <= 16'd0;
      heater     <= 1'b0;
      pump       <= 1'b0;
      act_total  <= 5'd0;
      for (int i = 0; i < NUM_WORKFLOWS; i++) begin
        counts[i] <= 5'd0;
      end
    end else begin
      if (cfg_write_en) begin
        wf_limit <= cfg_write_data;
      end
      run        <= run_next;
      act_wf     <= act_wf_next;
      act_step   <= act_step_next;
      start_time <= start_time_next;
      begin_val  <= begin_val_next;
      latest     <= latest_next;
      setpoint   <= setpoint_next;
      heater     <= heater_next;
      pump       <= pump_next;
      act_total  <= act_total_next;
      counts     <= counts_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_op  <= OP_SET_TEMP;
      cur_val <= 16'd0;
    end else begin
      cur_op  <= cur_op_next;
      cur_val <= cur_val_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/heater_pump_recipe_sequencer_top.sv @@
// Top level of the heater and pump recipe sequencer: request and result staging.
//
// Runs stored heater and pump recipes, one request per cycle: a request is taken
// into an input register, processed against the recipe state once the result
// register is free and written to the result register, so a result is offered
// from the cycle after its request is processed, and a new request is taken every
// cycle while results are being taken. The step table sits in a memory with one
// write port and one registered read port; the entry a request will need (the
// next step of the running workflow, or step 0 of the workflow being started) is
// read while that request is being accepted, so it is ready when the request is
// processed. The step table has no reset and needs no clearing pass: entries that
// were never written read back as unknown. The user must write workflow_count
// through cfg_write_en and cfg_write_data while the block is idle (not enforced).
`default_nettype none

module heater_pump_recipe_sequencer_top #(
  parameter int NUM_WORKFLOWS = hprs_pkg::NUM_WORKFLOWS_DEF,
  parameter int MAX_STEPS     = hprs_pkg::MAX_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [3:0]  cfg_write_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  action,
  input  logic [2:0]  workflow_index,
  input  logic [3:0]  step_index,
  input  logic [1:0]  step_op,
  input  logic [15:0] step_value,
  input  logic [4:0]  step_count,
  input  logic [31:0] now_ms,
  input  logic [15:0] current_temp,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        running,
  output logic [4:0]  step_position,
  output logic [4:0]  step_total,
  output logic [1:0]  current_op,
  output logic [15:0] start_value,
  output logic [15:0] current_value,
  output logic [15:0] target_temp,
  output logic        heater_on,
  output logic        pump_on,
  output logic        finished
);
  import hprs_pkg::*;

  localparam int MEM_DEPTH = NUM_WORKFLOWS * MAX_STEPS;
  localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  logic        in_full;
  item_t       item_q;
  result_t     res_q;
  result_t     res_next;
  logic        proc;
  logic        in_accept;

  logic              wr_en;
  logic [MEM_AW-1:0] wr_addr;
  step_entry_t       wr_data;
  logic              rd_en;
  logic [MEM_AW-1:0] rd_addr;
  step_entry_t       rd_data;

  assign proc      = in_full && (!out_valid || out_ready);
  assign in_ready  = !in_full || proc;
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_accept) begin
        in_full <= 1'b1;
      end else if (proc) begin
        in_full <= 1'b0;
      end
      if (proc) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_q <= '{action: action, wf: workflow_index, st: step_index, op: step_op,
                  val: step_value, cnt: step_count, now: now_ms, temp: current_temp};
    end
    if (proc) begin
      res_q <= res_next;
    end
  end

  hprs_core #(
    .NUM_WORKFLOWS (NUM_WORKFLOWS),
    .MAX_STEPS     (MAX_STEPS),
    .MEM_AW        (MEM_AW)
  ) u_core (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .proc           (proc),
    .item           (item_q),
    .in_accept      (in_accept),
    .in_action      (action),
    .in_wf          (workflow_index),
    .rd_data        (rd_data),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .rd_en          (rd_en),
    .rd_addr        (rd_addr),
    .result         (res_next)
  );

  hprs_step_mem #(
    .DEPTH (MEM_DEPTH),
    .AW    (MEM_AW)
  ) u_step_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign running       = res_q.running;
  assign step_position = res_q.step_position;
  assign step_total    = res_q.step_total;
  assign current_op    = res_q.current_op;
  assign start_value   = res_q.start_value;
  assign current_value = res_q.current_value;
  assign target_temp   = res_q.target_temp;
  assign heater_on     = res_q.heater_on;
  assign pump_on       = res_q.pump_on;
  assign finished      = res_q.finished;

endmodule

`default_nettype wire
